/* sv/lrt_pkg.sv */
// Shared types and constants for the LRU recency tracker.
// No dependencies; every other file but lrt_ram imports this package.
package lrt_pkg;

  localparam int ENTRIES_DEF  = 1024;
  localparam int KEY_BITS_DEF = 64;
  localparam int PORT_KEY_W   = 64;
  localparam int CAP_W        = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EV_RD,
    ST_EV_CAP,
    ST_UNL_RD,
    ST_UNL_WR,
    ST_LINK,
    ST_INSERT,
    ST_FINISH
  } lrt_state_t;

  typedef struct packed {
    logic load_key;
    logic scan_start;
    logic scan_run;
    logic sel_hit;
    logic sel_oldest;
    logic key_rd_oldest;
    logic ev_cap;
    logic unl_wr;
    logic link;
    logic insert;
    logic finish;
  } lrt_cmd_t;

  typedef struct packed {
    logic match;
    logic exhausted;
    logic full;
    logic hit_is_newest;
    logic fill_zero;
    logic fill_one;
    logic out_free;
  } lrt_status_t;

endpackage

/* sv/lrt_req_if.sv */
// Request channel: one key per beat, valid/ready handshake.
// Depends on lrt_pkg.
interface lrt_req_if import lrt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PORT_KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

/* sv/lrt_rsp_if.sv */
// Response channel: one lookup result per beat, valid/ready handshake.
// Depends on lrt_pkg.
interface lrt_rsp_if import lrt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic                  evicted_valid;
  logic [PORT_KEY_W-1:0] evicted_key;

  modport source (output valid, output hit, output evicted_valid, output evicted_key,
                  input ready);
  modport sink   (input valid, input hit, input evicted_valid, input evicted_key,
                  output ready);
endinterface

/* sv/lru_recency_tracker_unit.sv */
// LRU recency tracker. From acceptance to a valid result, a key goes through a lookup
// scan (skipped for an empty store); a hit on the newest key then finishes, any other hit
// is unlinked and relinked at the head of the recency chain, a miss on a store that is
// not full is inserted into the next free slot, and a miss on a full store evicts the
// oldest key and reuses its slot. A result may wait for the result register to drain.
// The lookup walks the filled slots of the key RAM one per cycle through its single read
// port, then unlink and relink of the recency chain read and write the link RAMs. One
// key is in work at a time; the result register lets the next key be accepted while a
// result waits. No clearing pass is needed after reset: slots fill in order, so the
// fill count marks validity.
// Depends on lrt_pkg, lrt_req_if, lrt_rsp_if, lrt_ctrl, lrt_datapath.
module lru_recency_tracker_unit import lrt_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  lrt_req_if.sink          req,
  lrt_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  lrt_cmd_t    cmd;
  lrt_status_t status;

  lrt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
    .status(status), .cmd(cmd)
  );

  lrt_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .req_key(req.key),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.hit),
    .rsp_evicted_valid(rsp.evicted_valid), .rsp_evicted_key(rsp.evicted_key)
  );

endmodule

/* sv/lrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lrt_ctrl.sv */
// Sequencer for lookup, unlink, relink and insert of one key.
// Depends on lrt_pkg; drives lrt_datapath through lrt_cmd_t.
module lrt_ctrl import lrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  lrt_status_t status,
  output lrt_cmd_t    cmd
);

  lrt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_key   = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = status.fill_zero ? ST_INSERT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.match) begin
          cmd.sel_hit = 1'b1;
          state_next  = status.hit_is_newest ? ST_FINISH : ST_UNL_RD;
        end else if (status.exhausted) begin
          state_next = status.full ? ST_EV_RD : ST_INSERT;
        end
      end
      ST_EV_RD: begin
        cmd.key_rd_oldest = 1'b1;
        cmd.sel_oldest    = 1'b1;
        state_next        = ST_EV_CAP;
      end
      ST_EV_CAP: begin
        cmd.ev_cap = 1'b1;
        state_next = status.fill_one ? ST_FINISH : ST_UNL_RD;
      end
      ST_UNL_RD: begin
        state_next = ST_UNL_WR;
      end
      ST_UNL_WR: begin
        cmd.unl_wr = 1'b1;
        state_next = ST_LINK;
      end
      ST_LINK: begin
        cmd.link   = 1'b1;
        state_next = ST_FINISH;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/lrt_datapath.sv */
// Key store, recency chain links, scan counter, pointers and result register.
// Depends on lrt_pkg and lrt_ram; commanded by lrt_ctrl.
module lrt_datapath import lrt_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lrt_cmd_t              cmd,
  output lrt_status_t           status,
  input  logic [PORT_KEY_W-1:0] req_key,
  input  logic                  cfg_we,
  input  logic [CAP_W-1:0]      cfg_wdata,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic                  rsp_hit,
  output logic                  rsp_evicted_valid,
  output logic [PORT_KEY_W-1:0] rsp_evicted_key
);

  localparam int IW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int CW = (FW > CAP_W) ? FW : CAP_W;
  localparam logic [FW-1:0] FILL_MAX = FW'(ENTRIES);

  logic [KEY_BITS-1:0] key_reg;
  logic [FW-1:0]       fill;
  logic [IW-1:0]       newest, oldest, slot;
  logic [FW-1:0]       scan_idx;
  logic                cmp_vld;
  logic [IW-1:0]       cmp_idx;
  logic [CAP_W-1:0]    capacity;
  logic                hit_r, ev_valid_r;
  logic [KEY_BITS-1:0] ev_key_r;

  logic                key_we;
  logic [IW-1:0]       key_waddr, key_raddr;
  logic [KEY_BITS-1:0] key_rdata;
  logic                old_we, new_we;
  logic [IW-1:0]       old_waddr, old_wdata, old_rdata;
  logic [IW-1:0]       new_waddr, new_wdata, new_rdata;
  logic [IW-1:0]       fill_idx, lnk_s;
  logic                scan_more;
  logic [CW-1:0]       fill_x, cap_x;

  assign fill_idx  = fill[IW-1:0];
  assign lnk_s     = cmd.insert ? fill_idx : slot;
  assign scan_more = scan_idx < fill;
  assign fill_x    = CW'(fill);
  assign cap_x     = CW'(capacity);

  // Key store port selection
  assign key_raddr = cmd.key_rd_oldest ? oldest : scan_idx[IW-1:0];
  assign key_we    = cmd.ev_cap | cmd.insert;
  assign key_waddr = cmd.insert ? fill_idx : slot;

  // Link writes: unlink uses the neighbors read at slot, relink puts lnk_s at the head
  always_comb begin
    old_we    = 1'b0;
    old_waddr = lnk_s;
    old_wdata = newest;
    new_we    = 1'b0;
    new_waddr = newest;
    new_wdata = lnk_s;
    if (cmd.unl_wr) begin
      old_we    = 1'b1;
      old_waddr = new_rdata;
      old_wdata = old_rdata;
      new_we    = (slot != oldest);
      new_waddr = old_rdata;
      new_wdata = new_rdata;
    end else if (cmd.link || (cmd.insert && (fill != '0))) begin
      old_we = 1'b1;
      new_we = 1'b1;
    end
  end

  lrt_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_reg),
    .raddr(key_raddr), .rdata(key_rdata)
  );

  lrt_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_older_ram (
    .clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
    .raddr(slot), .rdata(old_rdata)
  );

  lrt_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_newer_ram (
    .clk(clk), .we(new_we), .waddr(new_waddr), .wdata(new_wdata),
    .raddr(slot), .rdata(new_rdata)
  );

  always_comb begin
    status.match         = cmp_vld && (key_rdata == key_reg);
    status.exhausted     = !scan_more && !cmp_vld;
    status.full          = (fill == FILL_MAX) || (capacity == '0 ? fill != '0 : fill_x >= cap_x);
    status.hit_is_newest = (cmp_idx == newest);
    status.fill_zero     = (fill == '0);
    status.fill_one      = (fill == FW'(1));
    status.out_free      = !rsp_valid || rsp_ready;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      newest    <= '0;
      oldest    <= '0;
      cmp_vld   <= 1'b0;
      capacity  <= CAP_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (cmd.scan_start) begin
        cmp_vld <= 1'b0;
      end else if (cmd.scan_run) begin
        cmp_vld <= scan_more;
      end
      if (cmd.unl_wr && (slot == oldest)) begin
        oldest <= new_rdata;
      end
      if (cmd.link) begin
        newest <= slot;
      end
      if (cmd.insert) begin
        newest <= fill_idx;
        if (fill == '0) begin
          oldest <= fill_idx;
        end
        fill <= fill + FW'(1);
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key_reg    <= req_key[KEY_BITS-1:0];
      hit_r      <= 1'b0;
      ev_valid_r <= 1'b0;
      ev_key_r   <= '0;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_run && scan_more) begin
      scan_idx <= scan_idx + FW'(1);
      cmp_idx  <= scan_idx[IW-1:0];
    end
    if (cmd.sel_hit) begin
      slot  <= cmp_idx;
      hit_r <= 1'b1;
    end
    if (cmd.sel_oldest) begin
      slot <= oldest;
    end
    if (cmd.ev_cap) begin
      ev_key_r   <= key_rdata;
      ev_valid_r <= 1'b1;
    end
    if (cmd.finish) begin
      rsp_hit           <= hit_r;
      rsp_evicted_valid <= ev_valid_r;
      rsp_evicted_key   <= PORT_KEY_W'(ev_key_r);
    end
  end

endmodule

/* sv/lrt_checker.sv */
// Port-level checks for lru_recency_tracker_unit, attached by bind.
// Depends on lrt_pkg.
module lrt_checker import lrt_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic                  rsp_hit,
  input logic                  rsp_evicted_valid,
  input logic [PORT_KEY_W-1:0] rsp_evicted_key
);

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_hit |-> !rsp_evicted_valid)
    else $error("hit reported together with an eviction");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_evicted_valid |-> rsp_evicted_key == '0)
    else $error("evicted key not zero without eviction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a second key while one is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_evicted_key) && $stable(rsp_hit))
    else $error("stalled result beat changed");

endmodule

bind lru_recency_tracker_unit lrt_checker u_lrt_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.hit),
  .rsp_evicted_valid(rsp.evicted_valid), .rsp_evicted_key(rsp.evicted_key)
);

/* sim/tb.sv */
// Testbench for the LRU recency tracker: drives keys through the request channel,
// predicts hit/eviction per key with its own recency list, checks each response.
// Depends on lrt_pkg, lrt_req_if, lrt_rsp_if, lru_recency_tracker_unit.
module tb;
  import lrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        hit;
    logic        ev_valid;
    logic [63:0] ev_key;
  } lookup_res_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CAP_W-1:0] cfg_wdata = '0;

  lrt_req_if req ();
  lrt_rsp_if rsp ();

  lru_recency_tracker_unit dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // recency list: index 0 is newest
  logic [63:0] recency_q[$];
  int unsigned cap_reg = 1024;
  lookup_res_t expected_q[$];
  int mismatches = 0;
  int idle_pct = 14;
  bit hold_rsp = 0;
  logic [63:0] used_keys[$];

  function automatic lookup_res_t predict_lookup(logic [63:0] k);
    lookup_res_t r;
    int unsigned lim;
    int pos;
    r = '0;
    lim = (cap_reg == 0) ? 1 : (cap_reg > 1024 ? 1024 : cap_reg);
    pos = -1;
    foreach (recency_q[i]) if (recency_q[i] == k) begin
      pos = i;
      break;
    end
    if (pos >= 0) begin
      r.hit = 1;
      recency_q.delete(pos);
    end else if (recency_q.size() >= lim) begin
      r.ev_valid = 1;
      r.ev_key = recency_q[$];
      recency_q.delete(recency_q.size() - 1);
    end
    recency_q.insert(0, k);
    return r;
  endfunction

  initial begin
    req.valid = 0;
    req.key = '0;
    rsp.ready = 0;
  end

  task automatic send_key(logic [63:0] k);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      req.valid <= 0;
      @(posedge clk);
    end
    req.valid <= 1;
    req.key <= k;
    expected_q.insert(expected_q.size(), predict_lookup(k));
    used_keys.insert(used_keys.size(), k);
    if (used_keys.size() > 64) void'(used_keys.pop_front());
    do @(posedge clk); while (!req.ready);
  endtask

  // response side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) rsp.ready <= 0;
    else rsp.ready <= !hold_rsp && !(idle_pct > 0 && $urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response beat");
      end else begin
        lookup_res_t e;
        e = expected_q.pop_front();
        if (rsp.hit !== e.hit || rsp.evicted_valid !== e.ev_valid ||
            rsp.evicted_key !== e.ev_key) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hit=%0b ev=%0b key=%h, got hit=%0b ev=%0b key=%h",
                     e.hit, e.ev_valid, e.ev_key, rsp.hit, rsp.evicted_valid,
                     rsp.evicted_key);
        end
      end
    end
  end

  task automatic drain();
    req.valid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_capacity(int unsigned c);
    drain();
    cfg_we <= 1;
    cfg_wdata <= c[CAP_W-1:0];
    @(posedge clk);
    cfg_we <= 0;
    cap_reg = c & 11'h7FF;
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // pick from a small pool so that hits and evictions both happen
  function automatic logic [63:0] pool_key(int n);
    if (used_keys.size() > 0 && $urandom_range(99) < 55)
      return used_keys[$urandom_range(used_keys.size() - 1)];
    return {32'h0, $urandom_range(n - 1)} ^ 64'hA5A5_0000_0000_0000;
  endfunction

  task automatic test_directed();
    send_key(64'h0);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    send_key(64'h0);
    send_key(64'h8000_0000_0000_0001);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    set_capacity(2);
    send_key(64'h5555_5555_5555_5555);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);
    send_key(64'h5555_5555_5555_5555);
    // capacity zero acts as one
    set_capacity(0);
    send_key(64'h1);
    send_key(64'h2);
    send_key(64'h2);
    // above the store size saturates
    set_capacity(2047);
    send_key(64'h3);
    send_key(64'h4);
    send_key(64'h3);
    // lower below the fill: each miss evicts one
    set_capacity(1);
    send_key(64'h5);
    send_key(64'h6);
    send_key(64'h4);
  endtask

  task automatic test_random(int unsigned cap, int n, int pool);
    set_capacity(cap);
    for (int i = 0; i < n; i++)
      send_key(($urandom_range(9) == 0) ? rand_key() : pool_key(pool));
  endtask

  task automatic test_backpressure();
    idle_pct = 0;
    hold_rsp = 1;
    fork
      for (int i = 0; i < 10; i++) send_key(pool_key(8));
      begin
        repeat (300) @(posedge clk);
        hold_rsp = 0;
      end
    join
    idle_pct = 14;
  endtask

  task automatic test_fill_large();
    // fill the whole store, then overflow it
    set_capacity(1024);
    idle_pct = 0;
    for (int i = 0; i < 1030; i++) send_key({32'hC0DE_0000, i[31:0]});
    idle_pct = 14;
    send_key({32'hC0DE_0000, 32'd1029});
    send_key({32'hC0DE_0000, 32'd7});
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(4, 150, 8);
    test_backpressure();
    test_random(1, 60, 4);
    test_random(16, 180, 24);
    test_fill_large();
    test_random(3, 200, 6);
    drain();
    if (mismatches == 0 && expected_q.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("tb failed");
    $finish;
  end
endmodule

/* filelist.f */
sv/lrt_pkg.sv
sv/lrt_req_if.sv
sv/lrt_rsp_if.sv
sv/lrt_ram.sv
sv/lrt_ctrl.sv
sv/lrt_datapath.sv
sv/lru_recency_tracker_unit.sv
sv/lrt_checker.sv
sim/tb.sv
